// ===== rtl/qdr_pkg.sv =====
// Shared types, codes and transition table for the quadrature delta report block.
package qdr_pkg;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_READ   = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STEP_NONE = 2'b00,
        STEP_UP   = 2'b01,
        STEP_DOWN = 2'b10
    } step_t;

    localparam int COUNT_W = 16;
    localparam int TICK_W  = 32;
    localparam int MPC_W   = 32;
    localparam int DIST_W  = 32;
    localparam int FRAC_W  = 16;

    // index is {old_a, old_b, new_a, new_b}
    function automatic step_t step_of(input logic [3:0] idx);
        step_t s;
        case (idx)
            4'h1, 4'h7, 4'hE, 4'h8: s = STEP_UP;
            4'h2, 4'h4, 4'hD, 4'hB: s = STEP_DOWN;
            default:                s = STEP_NONE;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/quadrature_decoder_delta_report.sv =====
// Quadrature x4 decoder with tick counter and registered delta/distance report.
//
// Input channel (s_*): one transaction per item. mode 0 samples the A/B pin
// levels, mode 1 advances the saturating elapsed-tick counter, mode 2 requests
// a report, mode 3 zeroes the pulse count. Only mode 2 produces a result.
// Result channel (m_*): delta count since the previous report, distance in
// meters as Q16.16 (delta times meters_per_count, rounded half away from
// zero), elapsed ticks and the present count.
// Config channel (cfg_*): writes meters_per_count (Q0.32); always ready.
// A report appears on m_* in the cycle after its input transaction.
// Throughput: one item per cycle while the result channel does not stall; state
// updates and the 16x32 distance multiply are combinational between the state
// registers and the output register.
// Reset (aresetn low, synchronous): count, previous pin state, last-read
// count, tick counter and meters_per_count clear; the output register empties.
// Stall: while a report waits on m_ready, s_ready is low unless that report
// is being taken in the same cycle.
module quadrature_decoder_delta_report
    import qdr_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [MPC_W-1:0]          cfg_wdata,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_mode,
    input  logic                      s_level_a,
    input  logic                      s_level_b,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COUNT_W-1:0] m_delta_count,
    output logic signed [DIST_W-1:0]  m_distance_q16,
    output logic [TICK_W-1:0]         m_elapsed_ticks,
    output logic signed [COUNT_W-1:0] m_current_count
);

    logic [MPC_W-1:0]   mpc_reg;
    logic [1:0]         prev_ab_reg, prev_ab_next;
    logic               prev_valid_reg, prev_valid_next;
    logic [COUNT_W-1:0] pulse_count_reg, pulse_count_next;
    logic [COUNT_W-1:0] last_read_reg, last_read_next;
    logic [TICK_W-1:0]  tick_count_reg, tick_count_next;

    logic                      out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]        out_delta_reg;
    logic [DIST_W-1:0]         out_dist_reg;
    logic [TICK_W-1:0]         out_ticks_reg;
    logic [COUNT_W-1:0]        out_count_reg;

    logic                      s_fire;
    logic                      read_fire;
    mode_t                     mode;
    logic [1:0]                cur_ab;
    step_t                     step;
    logic [COUNT_W-1:0]        delta;
    logic signed [COUNT_W+MPC_W:0] prod;
    logic signed [COUNT_W+MPC_W:0] rounded;

    assign cfg_ready = 1'b1;
    assign s_ready   = !out_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign mode      = mode_t'(s_mode);
    assign read_fire = s_fire && (mode == MODE_READ);
    assign cur_ab    = {s_level_a, s_level_b};
    assign step      = step_of({prev_ab_reg, cur_ab});

    assign delta   = pulse_count_reg - last_read_reg;
    assign prod    = $signed(delta) * $signed({1'b0, mpc_reg});
    // round magnitude half away from zero
    assign rounded = prod + (prod[COUNT_W+MPC_W]
                     ? (COUNT_W+MPC_W+1)'(17'h07FFF)
                     : (COUNT_W+MPC_W+1)'(17'h08000));

    always_comb begin
        prev_ab_next     = prev_ab_reg;
        prev_valid_next  = prev_valid_reg;
        pulse_count_next = pulse_count_reg;
        last_read_next   = last_read_reg;
        tick_count_next  = tick_count_reg;
        if (s_fire) begin
            case (mode)
                MODE_SAMPLE: begin
                    prev_ab_next    = cur_ab;
                    prev_valid_next = 1'b1;
                    if (prev_valid_reg) begin
                        case (step)
                            STEP_UP:   pulse_count_next = pulse_count_reg + COUNT_W'(1);
                            STEP_DOWN: pulse_count_next = pulse_count_reg - COUNT_W'(1);
                            default:   pulse_count_next = pulse_count_reg;
                        endcase
                    end
                end
                MODE_TICK: begin
                    if (tick_count_reg != '1) begin
                        tick_count_next = tick_count_reg + TICK_W'(1);
                    end
                end
                MODE_READ: begin
                    last_read_next  = pulse_count_reg;
                    tick_count_next = '0;
                end
                default: begin
                    pulse_count_next = '0;
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (read_fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mpc_reg         <= '0;
            prev_ab_reg     <= '0;
            prev_valid_reg  <= 1'b0;
            pulse_count_reg <= '0;
            last_read_reg   <= '0;
            tick_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mpc_reg <= cfg_wdata;
            end
            prev_ab_reg     <= prev_ab_next;
            prev_valid_reg  <= prev_valid_next;
            pulse_count_reg <= pulse_count_next;
            last_read_reg   <= last_read_next;
            tick_count_reg  <= tick_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (read_fire) begin
            out_delta_reg <= delta;
            out_dist_reg  <= rounded[FRAC_W+DIST_W-1:FRAC_W];
            out_ticks_reg <= tick_count_reg;
            out_count_reg <= pulse_count_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_delta_count   = $signed(out_delta_reg);
    assign m_distance_q16  = $signed(out_dist_reg);
    assign m_elapsed_ticks = out_ticks_reg;
    assign m_current_count = $signed(out_count_reg);

    a_read_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        read_fire |=> m_valid)
        else $error("report transaction did not produce a result");

    a_read_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        read_fire |=> (tick_count_reg == '0) && (last_read_reg == out_count_reg))
        else $error("report did not restart ticks or remember count");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        (!read_fire && (!out_valid_reg || m_ready)) |=> !m_valid)
        else $error("result appeared without a report transaction");

    a_delta_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        read_fire |=> (out_count_reg - out_delta_reg) == $past(last_read_reg))
        else $error("delta count inconsistent with last read count");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the quadrature x4 decoder with delta/distance report.
`timescale 1ns / 1ps

module tb_top
    import qdr_pkg::*;
();

    typedef struct packed {
        logic [15:0] delta;
        logic [31:0] distance;
        logic [31:0] ticks;
        logic [15:0] count;
    } report_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [MPC_W-1:0]          cfg_wdata;
    logic                      s_valid;
    logic                      s_ready;
    logic [1:0]                s_mode;
    logic                      s_level_a;
    logic                      s_level_b;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [COUNT_W-1:0] m_delta_count;
    logic signed [DIST_W-1:0]  m_distance_q16;
    logic [TICK_W-1:0]         m_elapsed_ticks;
    logic signed [COUNT_W-1:0] m_current_count;

    // predictor state
    logic [1:0]  enc_ab = 2'b00;
    bit          enc_primed = 1'b0;
    logic [15:0] enc_count = '0;
    logic [15:0] enc_count_at_read = '0;
    logic [31:0] tick_total = '0;
    logic [31:0] mpc_q032 = '0;

    report_t     pending_reports[$];
    int unsigned mismatch_count = 0;
    bit          idle_on = 1'b1;
    logic [1:0]  pin_ab = 2'b00;

    quadrature_decoder_delta_report dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_level_a       (s_level_a),
        .s_level_b       (s_level_b),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_delta_count   (m_delta_count),
        .m_distance_q16  (m_distance_q16),
        .m_elapsed_ticks (m_elapsed_ticks),
        .m_current_count (m_current_count)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // position on the Gray cycle 00,01,11,10; the mapping is its own inverse
    function automatic logic [1:0] gray_map(input logic [1:0] ab);
        return {ab[1], ab[1] ^ ab[0]};
    endfunction

    function automatic logic [31:0] expected_distance(input logic [15:0] delta);
        logic              neg;
        logic [15:0]       mag;
        longint unsigned   r;
        neg = delta[15];
        mag = neg ? 16'(-delta) : delta;
        r = ({48'd0, mag} * {32'd0, mpc_q032} + 64'h8000) >> 16;
        if (neg) begin
            if (r >= 64'h8000_0000)
                return 32'h8000_0000;
            return 32'd0 - r[31:0];
        end
        if (r > 64'h7FFF_FFFF)
            return 32'h7FFF_FFFF;
        return r[31:0];
    endfunction

    function automatic void decoder_update(input mode_t md, input logic [1:0] ab);
        logic [1:0] moved;
        report_t    rep;
        case (md)
            MODE_SAMPLE: begin
                if (!enc_primed) begin
                    enc_primed = 1'b1;
                end else begin
                    moved = gray_map(ab) - gray_map(enc_ab);
                    if (moved == 2'd1)
                        enc_count = enc_count + 16'd1;
                    else if (moved == 2'd3)
                        enc_count = enc_count - 16'd1;
                end
                enc_ab = ab;
            end
            MODE_TICK: begin
                if (tick_total != 32'hFFFF_FFFF)
                    tick_total = tick_total + 32'd1;
            end
            MODE_READ: begin
                rep.delta    = enc_count - enc_count_at_read;
                rep.distance = expected_distance(rep.delta);
                rep.ticks    = tick_total;
                rep.count    = enc_count;
                pending_reports.push_back(rep);
                enc_count_at_read = enc_count;
                tick_total = '0;
            end
            default: begin
                enc_count = '0;
            end
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic flag_mismatch(input string what, input longint expv, input longint actv);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, expv, actv);
    endtask

    // sends one input transaction; returns at the falling edge after acceptance
    task automatic push_item(input mode_t md, input logic [1:0] ab);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= md;
        s_level_a <= ab[1];
        s_level_b <= ab[0];
        do @(posedge aclk); while (!s_ready);
        decoder_update(md, ab);
        @(negedge aclk);
    endtask

    task automatic step_pins(input bit up);
        pin_ab = gray_map(gray_map(pin_ab) + (up ? 2'd1 : 2'd3));
        push_item(MODE_SAMPLE, pin_ab);
    endtask

    task automatic load_meters_per_count(input logic [31:0] value);
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        mpc_q032 = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // first sample only loads the pin state; register still at its reset value
    task automatic test_first_sample();
        pin_ab = 2'b11;
        push_item(MODE_SAMPLE, pin_ab);
        push_item(MODE_READ, 2'b00);
        step_pins(1'b1);
        push_item(MODE_READ, 2'b11);
    endtask

    task automatic test_transitions();
        load_meters_per_count(32'h0001_0000);
        repeat (4) step_pins(1'b1);
        repeat (4) step_pins(1'b0);
        pin_ab = ~pin_ab;
        push_item(MODE_SAMPLE, pin_ab);
        pin_ab = ~pin_ab;
        push_item(MODE_SAMPLE, pin_ab);
        step_pins(1'b1);
        pin_ab = ~pin_ab;
        push_item(MODE_SAMPLE, pin_ab);
        push_item(MODE_SAMPLE, pin_ab);
        repeat (3) push_item(MODE_TICK, 2'(($urandom)));
        push_item(MODE_READ, 2'b01);
    endtask

    task automatic test_clear();
        repeat (5) step_pins(1'b1);
        push_item(MODE_TICK, 2'b10);
        push_item(MODE_READ, 2'b00);
        repeat (2) step_pins(1'b1);
        push_item(MODE_CLEAR, 2'b11);
        push_item(MODE_TICK, 2'b01);
        push_item(MODE_READ, 2'b00);
        push_item(MODE_READ, 2'b00);
    endtask

    // count crosses zero in both directions
    task automatic test_count_wrap();
        idle_on = 1'b0;
        load_meters_per_count(32'hFFFF_FFFF);
        push_item(MODE_CLEAR, 2'b00);
        push_item(MODE_READ, 2'b00);
        repeat (3) step_pins(1'b0);
        push_item(MODE_READ, 2'b00);
        step_pins(1'b0);
        repeat (2) step_pins(1'b1);
        push_item(MODE_READ, 2'b00);
        repeat (6) step_pins(1'b1);
        push_item(MODE_READ, 2'b00);
        idle_on = 1'b1;
    endtask

    task automatic test_distance_rounding();
        logic [31:0] mpc_list[7];
        int unsigned n;
        mpc_list = '{32'h0, 32'h1, 32'h7FFF, 32'h8000, 32'h8000_0000, 32'hFFFF_FFFF,
                     $urandom};
        foreach (mpc_list[i]) begin
            load_meters_per_count(mpc_list[i]);
            n = $urandom_range(1, 6);
            repeat (n) step_pins(1'b1);
            push_item(MODE_READ, 2'b00);
            n = $urandom_range(1, 6);
            repeat (n) step_pins(1'b0);
            push_item(MODE_READ, 2'b00);
        end
    endtask

    task automatic test_random_traffic();
        logic [31:0] mpc_set[6];
        int unsigned r;
        int unsigned done;
        bit          up;
        mpc_set = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, $urandom, $urandom};
        up = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            idle_on = (ph != 2);
            load_meters_per_count(mpc_set[ph]);
            done = 0;
            while (done < 180) begin
                if ($urandom_range(0, 99) < 10)
                    up = ~up;
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    step_pins(up);
                end else if (r < 62) begin
                    pin_ab = 2'($urandom);
                    push_item(MODE_SAMPLE, pin_ab);
                end else if (r < 65) begin
                    pin_ab = ~pin_ab;
                    push_item(MODE_SAMPLE, pin_ab);
                end else if (r < 78) begin
                    push_item(MODE_TICK, 2'($urandom));
                end else if (r < 92) begin
                    push_item(MODE_READ, 2'($urandom));
                end else if (r < 95) begin
                    push_item(MODE_CLEAR, 2'($urandom));
                end else begin
                    push_item(MODE_SAMPLE, pin_ab);
                    continue;
                end
                done++;
            end
        end
        idle_on = 1'b1;
    endtask

    // result sink back-pressure
    initial begin
        int unsigned n;
        m_ready <= 1'b0;
        @(negedge aclk);
        forever begin
            n = $urandom_range(1, 12);
            m_ready <= 1'b1;
            repeat (n) @(negedge aclk);
            n = pick_gap();
            if (n != 0) begin
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                flag_mismatch("unexpected report, count", 0, m_current_count);
            end else begin
                want = pending_reports.pop_front();
                if (m_delta_count !== want.delta)
                    flag_mismatch("delta_count", want.delta, m_delta_count);
                if (m_distance_q16 !== want.distance)
                    flag_mismatch("distance_q16", want.distance, m_distance_q16);
                if (m_elapsed_ticks !== want.ticks)
                    flag_mismatch("elapsed_ticks", want.ticks, m_elapsed_ticks);
                if (m_current_count !== want.count)
                    flag_mismatch("current_count", want.count, m_current_count);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_mode    <= MODE_SAMPLE;
        s_level_a <= 1'b0;
        s_level_b <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_wdata <= '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        test_first_sample();
        test_transitions();
        test_clear();
        test_count_wrap();
        test_distance_rounding();
        test_random_traffic();

        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
